/* rtl/core/crcfr_pkg.sv */
// ----------------------------------------------------------------------------
// CRC frame receiver package
// Shared types, character codes and the CRC-16/MODBUS byte update.
// ----------------------------------------------------------------------------
package crcfr_pkg;

   localparam logic [7:0] CHAR_OPEN  = 8'h7B;  // '{'
   localparam logic [7:0] CHAR_SEP   = 8'h7C;  // '|'
   localparam logic [7:0] CHAR_CLOSE = 8'h7D;  // '}'

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   typedef enum logic [1:0] {
      REQ_LINE_BYTE = 2'd0,
      REQ_READ      = 2'd1,
      REQ_CONSUME   = 2'd2,
      REQ_CLEAR     = 2'd3
   } req_code_type;

   typedef enum logic [1:0] {
      REPLY_NONE = 2'd0,
      REPLY_ACK  = 2'd1,
      REPLY_RST  = 2'd2
   } reply_code_type;

   typedef enum logic [1:0] {
      RESP_UNKNOWN = 2'd0,
      RESP_SUCC    = 2'd1,
      RESP_FAIL    = 2'd2
   } resp_code_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'd0,
      ST_HEAD = 3'd1,
      ST_SEP  = 3'd2,
      ST_REJ  = 3'd3,
      ST_ACK  = 3'd4
   } parse_state_type;

   typedef struct packed {
      logic       en;
      logic [7:0] addr;
      logic [7:0] data;
   } mem_wr_type;

   typedef struct packed {
      logic       en;
      logic [6:0] addr;
   } mem_rd_type;

   // Result fields known right after the state update; read data joins later.
   typedef struct packed {
      logic [1:0] reply_code;
      logic       frame_good;
      logic [1:0] link_response;
      logic [7:0] available_len;
      logic       read_hit;
   } stage_type;

   typedef struct packed {
      logic [1:0] reply_code;
      logic       frame_good;
      logic [1:0] link_response;
      logic [7:0] available_len;
      logic [7:0] read_data;
   } rsp_payload_type;

   function automatic logic [15:0] crc16_byte(input logic [15:0] crc_i,
                                              input logic [7:0]  data_i);
      logic [15:0] c;
      c = crc_i ^ {8'h00, data_i};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

/* rtl/core/crcfr_ifs.sv */
// ----------------------------------------------------------------------------
// CRC frame receiver channels
// Valid/ready channels for request words and response words.
// ----------------------------------------------------------------------------
interface crcfr_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] req_type;
   logic [7:0] rx_byte;
   logic [6:0] read_index;

   modport source (output valid, output req_type, output rx_byte, output read_index,
                   input ready);
   modport sink (input valid, input req_type, input rx_byte, input read_index,
                 output ready);
endinterface

interface crcfr_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] reply_code;
   logic       frame_good;
   logic [1:0] link_response;
   logic [7:0] available_len;
   logic [7:0] read_data;

   modport source (output valid, output reply_code, output frame_good,
                   output link_response, output available_len, output read_data,
                   input ready);
   modport sink (input valid, input reply_code, input frame_good,
                 input link_response, input available_len, input read_data,
                 output ready);
endinterface

/* rtl/core/crcfr_mem.sv */
// ----------------------------------------------------------------------------
// CRC frame receiver payload store
// Single-port-write, single-port-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module crcfr_mem #(
   parameter int MAX_PAYLOAD = 128
) (
   input  logic                 clock,
   input  crcfr_pkg::mem_wr_type wr,
   input  crcfr_pkg::mem_rd_type rd,
   output logic [7:0]           rdata
);
   import crcfr_pkg::*;

   localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

   logic [7:0] store_ff [MAX_PAYLOAD];
   logic [7:0] rdata_ff;
   logic [7:0] rd_addr_wide;

   assign rd_addr_wide = {1'b0, rd.addr};

   always_ff @(posedge clock) begin
      if (wr.en) begin
         store_ff[wr.addr[AW-1:0]] <= wr.data;
      end
   end

   // The read register holds while the stage it feeds is stalled.
   always_ff @(posedge clock) begin
      if (rd.en) begin
         rdata_ff <= store_ff[rd_addr_wide[AW-1:0]];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/core/crcfr_ctrl.sv */
// ----------------------------------------------------------------------------
// CRC frame receiver control
// Frame parser, running CRC, length and link response, plus the result stage.
// ----------------------------------------------------------------------------
module crcfr_ctrl #(
   parameter int MAX_PAYLOAD = 128
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  logic [1:0]            req_type,
   input  logic [7:0]            rx_byte,
   input  logic [6:0]            read_index,
   output crcfr_pkg::mem_wr_type wr,
   output crcfr_pkg::mem_rd_type rd,
   output crcfr_pkg::stage_type  stage
);
   import crcfr_pkg::*;

   localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);

   parse_state_type state_ff, state_in;
   logic [7:0]      length_ff, length_in;
   logic            pvalid_ff, pvalid_in;
   logic [15:0]     rcrc_ff, rcrc_in;
   logic [15:0]     crc_ff, crc_in;
   resp_code_type   resp_ff, resp_in;
   stage_type       stage_ff, stage_in;

   logic        is_line;
   logic [7:0]  avail_now;
   logic        crc_match;

   assign is_line   = (req_code_type'(req_type) == REQ_LINE_BYTE);
   assign avail_now = pvalid_ff ? length_ff : 8'd0;
   assign crc_match = ({crc_ff[7:0], crc_ff[15:8]} == rcrc_ff);

   // Parser next state.
   always_comb begin
      state_in = state_ff;
      if (is_line) begin
         if (rx_byte == CHAR_OPEN) begin
            state_in = ST_HEAD;
         end else if (rx_byte == CHAR_SEP && state_ff == ST_HEAD) begin
            state_in = (length_ff != 8'd0) ? ST_SEP : ST_REJ;
         end else if (rx_byte == CHAR_SEP && state_ff == ST_REJ) begin
            state_in = ST_ACK;
         end else if (rx_byte == CHAR_CLOSE &&
                      (state_ff == ST_SEP || state_ff == ST_REJ || state_ff == ST_ACK)) begin
            state_in = ST_IDLE;
         end
      end
   end

   // Datapath updates and result fields.
   always_comb begin
      length_in = length_ff;
      pvalid_in = pvalid_ff;
      rcrc_in   = rcrc_ff;
      crc_in    = crc_ff;
      resp_in   = resp_ff;
      wr        = '0;
      rd.en     = fire;
      rd.addr   = read_index;
      stage_in  = '0;
      stage_in.reply_code = REPLY_NONE;

      case (req_code_type'(req_type))
         REQ_LINE_BYTE: begin
            if (rx_byte == CHAR_OPEN) begin
               length_in = 8'd0;
               pvalid_in = 1'b0;
               rcrc_in   = 16'h0000;
               crc_in    = CRC_INIT;
            end else if (rx_byte == CHAR_SEP &&
                         (state_ff == ST_HEAD || state_ff == ST_REJ)) begin
               // Parser state change only.
            end else if (rx_byte == CHAR_CLOSE && state_ff == ST_SEP) begin
               if (crc_match) begin
                  pvalid_in           = 1'b1;
                  stage_in.reply_code = REPLY_ACK;
                  stage_in.frame_good = 1'b1;
               end else begin
                  stage_in.reply_code = REPLY_RST;
               end
            end else if (rx_byte == CHAR_CLOSE && state_ff == ST_REJ) begin
               resp_in = RESP_FAIL;
            end else if (rx_byte == CHAR_CLOSE && state_ff == ST_ACK) begin
               resp_in = RESP_SUCC;
            end else if (state_ff == ST_HEAD) begin
               if (length_ff < MAX_LEN) begin
                  wr.en     = fire;
                  wr.addr   = length_ff;
                  wr.data   = rx_byte;
                  length_in = length_ff + 8'd1;
                  crc_in    = crc16_byte(crc_ff, rx_byte);
               end
            end else if (state_ff == ST_SEP) begin
               rcrc_in = {rcrc_ff[7:0], rx_byte};
            end
         end
         REQ_READ: begin
            stage_in.read_hit = ({1'b0, read_index} < avail_now);
         end
         REQ_CONSUME: begin
            if (avail_now != 8'd0) begin
               length_in = 8'd0;
            end
         end
         REQ_CLEAR: begin
            resp_in = RESP_UNKNOWN;
         end
         default: begin
            resp_in = resp_ff;
         end
      endcase

      stage_in.link_response = resp_in;
      stage_in.available_len = pvalid_in ? length_in : 8'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         length_ff <= 8'd0;
         pvalid_ff <= 1'b0;
         rcrc_ff   <= 16'h0000;
         crc_ff    <= CRC_INIT;
         resp_ff   <= RESP_UNKNOWN;
      end else if (fire) begin
         state_ff  <= state_in;
         length_ff <= length_in;
         pvalid_ff <= pvalid_in;
         rcrc_ff   <= rcrc_in;
         crc_ff    <= crc_in;
         resp_ff   <= resp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         stage_ff <= stage_in;
      end
   end

   assign stage = stage_ff;

endmodule

/* rtl/core/crcfr_skid.sv */
// ----------------------------------------------------------------------------
// CRC frame receiver output buffer
// Two-entry skid buffer with a registered ready toward the pipeline.
// ----------------------------------------------------------------------------
module crcfr_skid (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   input  crcfr_pkg::rsp_payload_type in_data,
   output logic                       in_ready,
   output logic                       out_valid,
   output crcfr_pkg::rsp_payload_type out_data,
   input  logic                       out_ready
);
   import crcfr_pkg::*;

   logic            main_valid_ff, main_valid_in;
   logic            spare_valid_ff, spare_valid_in;
   rsp_payload_type main_ff, main_in;
   rsp_payload_type spare_ff, spare_in;
   logic            in_fire;

   assign in_ready = !spare_valid_ff;
   assign in_fire  = in_valid && in_ready;

   always_comb begin
      main_valid_in  = main_valid_ff;
      spare_valid_in = spare_valid_ff;
      main_in        = main_ff;
      spare_in       = spare_ff;
      if (!main_valid_ff || out_ready) begin
         if (spare_valid_ff) begin
            main_in        = spare_ff;
            main_valid_in  = 1'b1;
            spare_valid_in = 1'b0;
         end else begin
            main_in       = in_data;
            main_valid_in = in_fire;
         end
      end else if (in_fire) begin
         spare_in       = in_data;
         spare_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff  <= 1'b0;
         spare_valid_ff <= 1'b0;
      end else begin
         main_valid_ff  <= main_valid_in;
         spare_valid_ff <= spare_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      main_ff  <= main_in;
      spare_ff <= spare_in;
   end

   assign out_valid = main_valid_ff;
   assign out_data  = main_ff;

endmodule

/* rtl/core/crc_frame_receiver_unit.sv */
// ----------------------------------------------------------------------------
// CRC frame receiver
// Parses '{' payload '|' crc crc '}' frames from line bytes, stores the payload,
// checks CRC-16/MODBUS and answers read, consume and clear requests.
// A response word passes the result stage register, then the skid buffer's main
// register. Throughput: one request word per cycle unless the response path
// stalls; the payload RAM has one write and one read port, and each word writes
// at most one entry and reads one entry. Reset clears the parser, CRC, length,
// valid mark, link response; the payload RAM is not cleared and needs no sweep.
// ----------------------------------------------------------------------------
module crc_frame_receiver_unit #(
   parameter int MAX_PAYLOAD = 128
) (
   input  logic        clock,
   input  logic        reset,
   crcfr_req_if.sink   req_chan,
   crcfr_rsp_if.source rsp_chan
);
   import crcfr_pkg::*;

   logic            req_fire;
   logic            s1_valid_ff, s1_valid_in;
   logic            skid_ready;
   mem_wr_type      wr;
   mem_rd_type      rd;
   stage_type       stage;
   logic [7:0]      mem_rdata;
   rsp_payload_type s1_data;
   rsp_payload_type out_data;

   assign req_chan.ready = !s1_valid_ff || skid_ready;
   assign req_fire       = req_chan.valid && req_chan.ready;

   crcfr_ctrl #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .fire       (req_fire),
      .req_type   (req_chan.req_type),
      .rx_byte    (req_chan.rx_byte),
      .read_index (req_chan.read_index),
      .wr         (wr),
      .rd         (rd),
      .stage      (stage)
   );

   crcfr_mem #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_mem (
      .clock (clock),
      .wr    (wr),
      .rd    (rd),
      .rdata (mem_rdata)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (skid_ready) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   assign s1_data.reply_code    = stage.reply_code;
   assign s1_data.frame_good    = stage.frame_good;
   assign s1_data.link_response = stage.link_response;
   assign s1_data.available_len = stage.available_len;
   assign s1_data.read_data     = stage.read_hit ? mem_rdata : 8'd0;

   crcfr_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid_ff),
      .in_data   (s1_data),
      .in_ready  (skid_ready),
      .out_valid (rsp_chan.valid),
      .out_data  (out_data),
      .out_ready (rsp_chan.ready)
   );

   assign rsp_chan.reply_code    = out_data.reply_code;
   assign rsp_chan.frame_good    = out_data.frame_good;
   assign rsp_chan.link_response = out_data.link_response;
   assign rsp_chan.available_len = out_data.available_len;
   assign rsp_chan.read_data     = out_data.read_data;

endmodule

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// CRC frame receiver testbench
// Drives line bytes, reads, consumes and clears with random gaps on both
// channels, predicts every response word and compares it field by field.
// ----------------------------------------------------------------------------
module tb_top;
   import crcfr_pkg::*;

   localparam int PAYLOAD_DEPTH = 128;
   localparam int RANDOM_WORDS  = 1700;
   localparam int CYCLE_LIMIT   = 600000;
   localparam int SETTLE_CYCLES = 16;
   localparam int LONG_STALL    = 400;

   // Shadow of the receiver: parser, payload buffer, CRC and link response.
   class frame_scoreboard;
      parse_state_type  parse_st;
      logic [7:0]       payload_mem [PAYLOAD_DEPTH];
      int unsigned      payload_len;
      bit               payload_ok;
      logic [15:0]      rx_crc;
      logic [15:0]      calc_crc;
      resp_code_type    link_resp;
      int unsigned      written_top;
      int unsigned      error_count;
      rsp_payload_type  expected_q [$];

      function new();
         parse_st    = ST_IDLE;
         payload_len = 0;
         payload_ok  = 1'b0;
         rx_crc      = 16'h0000;
         calc_crc    = CRC_INIT;
         link_resp   = RESP_UNKNOWN;
         written_top = 0;
         error_count = 0;
      endfunction

      // Bit-serial, LSB-first form of the MODBUS polynomial.
      function logic [15:0] crc_after_byte(logic [15:0] crc, logic [7:0] b);
         logic [15:0] c;
         logic        fb;
         c = crc;
         for (int i = 0; i < 8; i++) begin
            fb = c[0] ^ b[i];
            c  = c >> 1;
            if (fb) begin
               c = c ^ CRC_POLY;
            end
         end
         return c;
      endfunction

      function int unsigned available();
         return payload_ok ? payload_len : 0;
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction

      function void note_request(req_code_type t, logic [7:0] b, logic [6:0] idx);
         rsp_payload_type e;
         e = '0;
         case (t)
            REQ_LINE_BYTE: begin
               if (b == CHAR_OPEN) begin
                  payload_len = 0;
                  payload_ok  = 1'b0;
                  rx_crc      = 16'h0000;
                  calc_crc    = CRC_INIT;
                  parse_st    = ST_HEAD;
               end else if (b == CHAR_SEP && parse_st == ST_HEAD) begin
                  parse_st = (payload_len > 0) ? ST_SEP : ST_REJ;
               end else if (b == CHAR_SEP && parse_st == ST_REJ) begin
                  parse_st = ST_ACK;
               end else if (b == CHAR_CLOSE && parse_st == ST_SEP) begin
                  // The line carries the low CRC byte first.
                  if ({calc_crc[7:0], calc_crc[15:8]} == rx_crc) begin
                     payload_ok   = 1'b1;
                     e.reply_code = REPLY_ACK;
                     e.frame_good = 1'b1;
                  end else begin
                     e.reply_code = REPLY_RST;
                  end
                  parse_st = ST_IDLE;
               end else if (b == CHAR_CLOSE && parse_st == ST_REJ) begin
                  link_resp = RESP_FAIL;
                  parse_st  = ST_IDLE;
               end else if (b == CHAR_CLOSE && parse_st == ST_ACK) begin
                  link_resp = RESP_SUCC;
                  parse_st  = ST_IDLE;
               end else if (parse_st == ST_HEAD) begin
                  if (payload_len < PAYLOAD_DEPTH) begin
                     payload_mem[payload_len] = b;
                     payload_len++;
                     if (payload_len > written_top) begin
                        written_top = payload_len;
                     end
                     calc_crc = crc_after_byte(calc_crc, b);
                  end
               end else if (parse_st == ST_SEP) begin
                  rx_crc = {rx_crc[7:0], b};
               end
            end
            REQ_READ: begin
               if (idx < available()) begin
                  e.read_data = payload_mem[idx];
               end
            end
            REQ_CONSUME: begin
               if (available() != 0) begin
                  payload_len = 0;
               end
            end
            default: begin
               link_resp = RESP_UNKNOWN;
            end
         endcase
         e.link_response = link_resp;
         e.available_len = 8'(available());
         expected_q.push_back(e);
      endfunction

      function void check_response(rsp_payload_type got);
         rsp_payload_type e;
         if (expected_q.size() == 0) begin
            $error("response word with no request outstanding");
            error_count++;
            return;
         end
         e = expected_q.pop_front();
         if (got.reply_code !== e.reply_code) begin
            $error("reply_code: expected %0d, got %0d", e.reply_code, got.reply_code);
            error_count++;
         end
         if (got.frame_good !== e.frame_good) begin
            $error("frame_good: expected %0d, got %0d", e.frame_good, got.frame_good);
            error_count++;
         end
         if (got.link_response !== e.link_response) begin
            $error("link_response: expected %0d, got %0d", e.link_response,
                   got.link_response);
            error_count++;
         end
         if (got.available_len !== e.available_len) begin
            $error("available_len: expected %0d, got %0d", e.available_len,
                   got.available_len);
            error_count++;
         end
         if (got.read_data !== e.read_data) begin
            $error("read_data: expected %0d, got %0d", e.read_data, got.read_data);
            error_count++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;

   crcfr_req_if req_bus ();
   crcfr_rsp_if rsp_bus ();

   crc_frame_receiver_unit #(
      .MAX_PAYLOAD(PAYLOAD_DEPTH)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   frame_scoreboard sb = new();
   int unsigned     cycle_count = 0;
   int unsigned     counted_words = 0;
   bit              sender_steady = 1'b0;
   bit              long_stall_req = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("** crc_frame_receiver_unit: FAILED **");
         $finish;
      end
   end

   initial begin
      req_bus.valid      <= 1'b0;
      req_bus.req_type   <= REQ_LINE_BYTE;
      req_bus.rx_byte    <= 8'h00;
      req_bus.read_index <= 7'd0;
      rsp_bus.ready      <= 1'b0;
   end

   // Response side: random hold-off per word, steady stretches, one long stall.
   initial begin : response_sink
      int unsigned     hold;
      int unsigned     since_toggle;
      bit              steady;
      rsp_payload_type got;
      hold         = 0;
      since_toggle = 0;
      steady       = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            got.reply_code    = rsp_bus.reply_code;
            got.frame_good    = rsp_bus.frame_good;
            got.link_response = rsp_bus.link_response;
            got.available_len = rsp_bus.available_len;
            got.read_data     = rsp_bus.read_data;
            sb.check_response(got);
            since_toggle++;
            if (since_toggle >= 64) begin
               steady       = ($urandom_range(0, 2) == 0);
               since_toggle = 0;
            end
            hold = steady ? 0 : $urandom_range(0, 12);
         end
         if (long_stall_req) begin
            hold           = LONG_STALL;
            long_stall_req = 1'b0;
         end
         if (hold > 0) begin
            rsp_bus.ready <= 1'b0;
            hold--;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   function automatic logic [7:0] draw_payload_byte();
      logic [7:0] b;
      do begin
         b = 8'($urandom_range(0, 255));
      end while (b == CHAR_OPEN || b == CHAR_SEP);
      return b;
   endfunction

   // Called right after the clock rises; returns right after the request word is accepted.
   task automatic send_word(input req_code_type t, input logic [7:0] b,
                            input logic [6:0] idx);
      int unsigned gap;
      gap = sender_steady ? 0 : $urandom_range(0, 12);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid      <= 1'b1;
      req_bus.req_type   <= t;
      req_bus.rx_byte    <= b;
      req_bus.read_index <= idx;
      do begin
         @(posedge clock);
      end while (req_bus.ready !== 1'b1);
      sb.note_request(t, b, idx);
      counted_words++;
   endtask

   task automatic send_line(input logic [7:0] b);
      send_word(REQ_LINE_BYTE, b, 7'($urandom_range(0, 127)));
   endtask

   // Data frame; the extremes pattern mixes 00, FF and the close character.
   task automatic send_frame(input int unsigned len, input bit bad_crc,
                             input bit extra_bar, input bit extremes);
      logic [15:0] crc;
      logic [7:0]  b;
      logic [7:0]  crc_lo;
      logic [7:0]  crc_hi;
      int unsigned k;
      crc = CRC_INIT;
      send_line(CHAR_OPEN);
      for (k = 0; k < len; k++) begin
         b = draw_payload_byte();
         if (extremes) begin
            case (k % 4)
               0: b = 8'h00;
               1: b = 8'hFF;
               2: b = CHAR_CLOSE;
               default: ;
            endcase
         end
         if (k < PAYLOAD_DEPTH) begin
            crc = sb.crc_after_byte(crc, b);
         end
         send_line(b);
      end
      send_line(CHAR_SEP);
      if (extra_bar) begin
         send_line(CHAR_SEP);
      end
      crc_lo = crc[7:0];
      crc_hi = crc[15:8];
      if (bad_crc) begin
         crc_hi = crc_hi ^ (8'h01 << $urandom_range(0, 7));
      end
      send_line(crc_lo);
      send_line(crc_hi);
      send_line(CHAR_CLOSE);
   endtask

   task automatic send_read(input logic [6:0] idx);
      send_word(REQ_READ, 8'($urandom_range(0, 255)), idx);
   endtask

   task automatic send_control(input req_code_type t);
      send_word(t, 8'($urandom_range(0, 255)), 7'($urandom_range(0, 127)));
   endtask

   // Only entries that have been written are ever read.
   task automatic send_random_read();
      int unsigned top;
      top = sb.available();
      if (top == 0 || $urandom_range(0, 1) == 0) begin
         top = sb.written_top;
      end
      if (top == 0) begin
         send_control(REQ_CONSUME);
      end else begin
         send_read(7'($urandom_range(0, top - 1)));
      end
   endtask

   task automatic drain_responses();
      req_bus.valid <= 1'b0;
      while (sb.pending() != 0) begin
         @(posedge clock);
      end
   endtask

   initial begin : stimulus
      int unsigned sel;
      int unsigned n;
      int unsigned mark;
      bit          stall_done;
      bit          pause_done;
      stall_done = 1'b0;
      pause_done = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed part.
      send_control(REQ_CLEAR);
      send_control(REQ_CONSUME);
      send_line(CHAR_OPEN);
      send_line(CHAR_SEP);
      send_line(CHAR_CLOSE);
      send_control(REQ_CLEAR);
      send_line(CHAR_OPEN);
      send_line(CHAR_SEP);
      send_line(CHAR_SEP);
      send_line(CHAR_CLOSE);
      send_line(CHAR_CLOSE);
      send_line(CHAR_SEP);
      send_line(8'h41);
      // Longer than the buffer, so the tail bytes are dropped from the CRC.
      send_frame(PAYLOAD_DEPTH + 2, 1'b0, 1'b0, 1'b1);
      send_read(7'd0);
      send_read(7'd127);
      send_read(7'd64);
      send_control(REQ_CONSUME);
      send_read(7'd0);
      send_control(REQ_CONSUME);
      send_frame(1, 1'b1, 1'b0, 1'b0);
      send_frame(3, 1'b0, 1'b1, 1'b1);
      send_read(7'd2);
      send_line(CHAR_OPEN);
      send_line(8'h61);
      send_line(8'h62);
      send_frame(2, 1'b0, 1'b0, 1'b0);
      send_read(7'd1);
      drain_responses();

      // Random part.
      counted_words = 0;
      while (counted_words < RANDOM_WORDS) begin
         if (!stall_done && counted_words > 600) begin
            long_stall_req = 1'b1;
            stall_done     = 1'b1;
         end
         if (!pause_done && counted_words > 1200) begin
            drain_responses();
            pause_done = 1'b1;
         end
         sender_steady = ($urandom_range(0, 4) == 0);
         sel = $urandom_range(0, 99);
         if (sel < 45) begin
            n = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 140)
                                              : $urandom_range(1, 12);
            send_frame(n, $urandom_range(0, 9) == 0, $urandom_range(0, 9) == 0,
                       $urandom_range(0, 7) == 0);
         end else if (sel < 55) begin
            send_line(CHAR_OPEN);
            send_line(CHAR_SEP);
            if ($urandom_range(0, 1) == 1) begin
               send_line(CHAR_SEP);
            end
            send_line(CHAR_CLOSE);
         end else if (sel < 63) begin
            // Line noise; mostly ignored, so it does not count.
            mark = counted_words;
            n = $urandom_range(1, 5);
            repeat (n) send_line(8'($urandom_range(0, 255)));
            counted_words = mark;
         end else if (sel < 70) begin
            // Broken frame, left open for the next one to restart.
            send_line(CHAR_OPEN);
            n = $urandom_range(0, 4);
            repeat (n) send_line(draw_payload_byte());
            if ($urandom_range(0, 1) == 1) begin
               send_line(CHAR_SEP);
               send_line(8'($urandom_range(0, 255)));
            end
         end else begin
            n = $urandom_range(1, 4);
            repeat (n) begin
               sel = $urandom_range(0, 9);
               if (sel < 6) begin
                  send_random_read();
               end else if (sel < 8) begin
                  send_control(REQ_CONSUME);
               end else begin
                  send_control(REQ_CLEAR);
               end
            end
         end
      end

      drain_responses();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.error_count == 0 && sb.pending() == 0) begin
         $display("** crc_frame_receiver_unit: PASSED **");
      end else begin
         $display("** crc_frame_receiver_unit: FAILED **");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/core/crcfr_pkg.sv
rtl/core/crcfr_ifs.sv
rtl/core/crcfr_mem.sv
rtl/core/crcfr_ctrl.sv
rtl/core/crcfr_skid.sv
rtl/core/crc_frame_receiver_unit.sv
test/tb_top.sv
